// ===== sv/bfsf_pkg.sv =====
`default_nettype none

package bfsf_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned EVENT_W   = 2;
    localparam int unsigned CFG_NUM   = 5;
    localparam int unsigned CFG_IDX_W = $clog2(CFG_NUM);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SYNC_FIRST     = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_SYNC_SECOND    = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_CLASS_VALUE    = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_MESSAGE_VALUE  = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_PAYLOAD_LENGTH = t_cfg_idx'(4);

    localparam logic [BYTE_W-1:0] RST_SYNC_FIRST     = 8'd181;
    localparam logic [BYTE_W-1:0] RST_SYNC_SECOND    = 8'd98;
    localparam logic [BYTE_W-1:0] RST_CLASS_VALUE    = 8'd1;
    localparam logic [BYTE_W-1:0] RST_MESSAGE_VALUE  = 8'd5;
    localparam logic [BYTE_W-1:0] RST_PAYLOAD_LENGTH = 8'd26;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CLASS   = 3'd2,
        PH_ID      = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CK_A    = 3'd5,
        PH_CK_B    = 3'd6
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_GOOD    = 2'd2,
        EV_BAD     = 2'd3
    } t_event;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] class_value;
        logic [BYTE_W-1:0] message_value;
        logic [BYTE_W-1:0] payload_length;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/bfsf_byte_if.sv =====
`default_nettype none

interface bfsf_byte_if import bfsf_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

// ===== sv/bfsf_evt_if.sv =====
`default_nettype none

interface bfsf_evt_if import bfsf_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  payload_byte;
    logic [BYTE_W-1:0]  byte_index;

    modport source (
        output valid, output event_res, output payload_byte, output byte_index,
        input ready
    );
    modport sink (
        input valid, input event_res, input payload_byte, input byte_index,
        output ready
    );

endinterface

`default_nettype wire

// ===== sv/bfsf_cfg_regs.sv =====
`default_nettype none

module bfsf_cfg_regs import bfsf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire t_cfg_idx          i_cfg_idx,
    input  wire logic [BYTE_W-1:0] i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first     <= RST_SYNC_FIRST;
            r_cfg.sync_second    <= RST_SYNC_SECOND;
            r_cfg.class_value    <= RST_CLASS_VALUE;
            r_cfg.message_value  <= RST_MESSAGE_VALUE;
            r_cfg.payload_length <= RST_PAYLOAD_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:     r_cfg.sync_first     <= i_cfg_data;
                CFG_SYNC_SECOND:    r_cfg.sync_second    <= i_cfg_data;
                CFG_CLASS_VALUE:    r_cfg.class_value    <= i_cfg_data;
                CFG_MESSAGE_VALUE:  r_cfg.message_value  <= i_cfg_data;
                CFG_PAYLOAD_LENGTH: r_cfg.payload_length <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/bfsf_frame_fsm.sv =====
`default_nettype none

module bfsf_frame_fsm import bfsf_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    bfsf_byte_if.sink   i_rx,
    bfsf_evt_if.source  o_evt
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_sum_a, n_sum_a;
    logic [BYTE_W-1:0] r_sum_b, n_sum_b;
    logic [BYTE_W-1:0] r_count, n_count;

    logic              r_out_valid;
    t_event            r_out_event, n_out_event;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic [BYTE_W-1:0] r_out_index, n_out_index;

    logic              advance;
    logic              do_work;
    logic              rehunt;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] count_inc;
    logic [BYTE_W-1:0] id_sum_a;
    logic [BYTE_W-1:0] pl_sum_a;

    assign advance    = !r_out_valid || o_evt.ready;
    assign do_work    = r_in_valid && advance;
    assign i_rx.ready = !r_in_valid || advance;
    assign b          = r_in_byte;
    assign count_inc  = r_count + BYTE_W'(1);
    assign id_sum_a   = r_sum_a + b;
    assign pl_sum_a   = r_sum_a + b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_work) begin
                r_phase <= n_phase;
                r_sum_a <= n_sum_a;
                r_sum_b <= n_sum_b;
                r_count <= n_count;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_work) begin
            r_out_event <= n_out_event;
            r_out_byte  <= n_out_byte;
            r_out_index <= n_out_index;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_count     = r_count;
        n_out_event = EV_NONE;
        n_out_byte  = '0;
        n_out_index = '0;
        rehunt      = 1'b0;
        case (r_phase)
            PH_SYNC2: begin
                if (b == i_cfg.sync_second) n_phase = PH_CLASS;
                else rehunt = 1'b1;
            end
            PH_CLASS: begin
                if (b == i_cfg.class_value) begin
                    n_phase = PH_ID;
                    n_sum_a = b;
                    n_sum_b = b;
                end else begin
                    rehunt = 1'b1;
                end
            end
            PH_ID: begin
                if (b == i_cfg.message_value) begin
                    n_phase = PH_PAYLOAD;
                    n_sum_a = id_sum_a;
                    n_sum_b = r_sum_b + id_sum_a;
                    n_count = '0;
                end else begin
                    rehunt = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_out_event = EV_PAYLOAD;
                n_out_byte  = b;
                n_out_index = r_count;
                n_count     = count_inc;
                n_sum_a     = pl_sum_a;
                n_sum_b     = r_sum_b + pl_sum_a;
                if (count_inc == i_cfg.payload_length) n_phase = PH_CK_A;
            end
            PH_CK_A: begin
                if (b == r_sum_a) begin
                    n_phase = PH_CK_B;
                end else begin
                    n_phase     = PH_HUNT;
                    n_out_event = EV_BAD;
                end
            end
            PH_CK_B: begin
                n_phase     = PH_HUNT;
                n_out_event = (b == r_sum_b) ? EV_GOOD : EV_BAD;
            end
            default: begin
                rehunt = 1'b1;
            end
        endcase
        if (rehunt) begin
            n_phase = (b == i_cfg.sync_first) ? PH_SYNC2 : PH_HUNT;
        end
    end

    assign o_evt.valid        = r_out_valid;
    assign o_evt.event_res    = r_out_event;
    assign o_evt.payload_byte = r_out_byte;
    assign o_evt.byte_index   = r_out_index;

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event != EV_PAYLOAD)
            |-> (r_out_byte == '0 && r_out_index == '0))
        else $error("non-payload result carries payload fields");

    a_ck_a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CK_A && $past(r_phase) != PH_CK_A)
            |-> ($past(r_phase) == PH_PAYLOAD))
        else $error("checksum phase entered from outside payload");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost or overwritten");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_work && r_phase == PH_CK_B)
            |=> (r_phase == PH_HUNT && r_out_valid
                 && (r_out_event == EV_GOOD || r_out_event == EV_BAD)))
        else $error("frame end not reported");

endmodule

`default_nettype wire

// ===== sv/binary_frame_sync_fletcher_check.sv =====
// Frame sync and Fletcher-8 check for a received byte stream.
// i_rx carries one received byte per transfer (valid/ready). o_evt returns
// exactly one result per byte: event_res (none, payload byte, frame good,
// checksum failure), with payload_byte and byte_index set for payload bytes
// and zero otherwise.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the two
// sync bytes, the class and id bytes and the payload length; write it only
// while no byte is in flight. Index values past the last register are ignored.
// Each byte goes through an input register and a result register; one byte
// is taken every cycle while the receiver does not stall. The step between
// them is the byte compares and a chain of two 8-bit adds for the sums.
// When the receiver stalls, the result register and then the input register
// hold; i_rx.ready drops only when both are full.
// Synchronous reset loads the register defaults, returns to hunting for the
// first sync byte, clears both sums and empties both registers.
`default_nettype none

module binary_frame_sync_fletcher_check import bfsf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire t_cfg_idx          i_cfg_idx,
    input  wire logic [BYTE_W-1:0] i_cfg_data,
    bfsf_byte_if.sink              i_rx,
    bfsf_evt_if.source             o_evt
);

    t_cfg cfg;

    bfsf_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bfsf_frame_fsm u_frame_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_rx    (i_rx),
        .o_evt   (o_evt)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfsf_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;

    typedef struct packed {
        t_event            ev;
        logic [BYTE_W-1:0] pb;
        logic [BYTE_W-1:0] idx;
    } t_evt_rec;

    typedef struct {
        logic [BYTE_W-1:0] data;
        bit                pinned;
        t_evt_rec          want;
    } t_dir_row;

    typedef struct {
        bit       pinned;
        t_evt_rec want;
    } t_pin;

    typedef enum int {
        FRAME_CLEAN,
        FRAME_CUT,
        FRAME_BAD_A,
        FRAME_BAD_B
    } t_flaw;

    localparam t_evt_rec NO_EVT  = '{EV_NONE, 8'h00, 8'h00};
    localparam t_evt_rec GOOD    = '{EV_GOOD, 8'h00, 8'h00};
    localparam t_evt_rec BAD     = '{EV_BAD, 8'h00, 8'h00};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_data;
    logic                 sink_ready = 1'b0;

    bfsf_byte_if rx_if ();
    bfsf_evt_if  evt_if ();

    assign evt_if.ready = sink_ready;

    binary_frame_sync_fletcher_check uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_if),
        .o_evt      (evt_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Deframer state as the predictor tracks it
    t_cfg              cfg_mirror = '{RST_SYNC_FIRST, RST_SYNC_SECOND, RST_CLASS_VALUE,
                                      RST_MESSAGE_VALUE, RST_PAYLOAD_LENGTH};
    t_phase            frame_phase = PH_HUNT;
    logic [BYTE_W-1:0] fletch_a = '0;
    logic [BYTE_W-1:0] fletch_b = '0;
    logic [BYTE_W-1:0] payload_seen = '0;

    t_evt_rec evt_expect_q [$];
    t_pin     pin_q [$];
    int       mismatches = 0;
    int       cycle_count = 0;
    int       stall_left = 0;
    bit       quiet = 1'b0;
    t_evt_rec want;
    t_evt_rec got;
    t_pin     pin;

    function automatic t_evt_rec deframe_step(input logic [BYTE_W-1:0] b);
        t_evt_rec r;
        bit       rehunt;
        r = NO_EVT;
        rehunt = 1'b0;
        case (frame_phase)
            PH_SYNC2: begin
                if (b == cfg_mirror.sync_second) frame_phase = PH_CLASS;
                else rehunt = 1'b1;
            end
            PH_CLASS: begin
                if (b == cfg_mirror.class_value) begin
                    frame_phase = PH_ID;
                    fletch_a = b;
                    fletch_b = b;
                end else begin
                    rehunt = 1'b1;
                end
            end
            PH_ID: begin
                if (b == cfg_mirror.message_value) begin
                    frame_phase = PH_PAYLOAD;
                    fletch_a = fletch_a + b;
                    fletch_b = fletch_b + fletch_a;
                    payload_seen = '0;
                end else begin
                    rehunt = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                r = '{EV_PAYLOAD, b, payload_seen};
                payload_seen = payload_seen + 8'd1;
                fletch_a = fletch_a + b;
                fletch_b = fletch_b + fletch_a;
                if (payload_seen == cfg_mirror.payload_length) frame_phase = PH_CK_A;
            end
            PH_CK_A: begin
                if (b == fletch_a) begin
                    frame_phase = PH_CK_B;
                end else begin
                    frame_phase = PH_HUNT;
                    r.ev = EV_BAD;
                end
            end
            PH_CK_B: begin
                frame_phase = PH_HUNT;
                r.ev = (b == fletch_b) ? EV_GOOD : EV_BAD;
            end
            default: rehunt = 1'b1;
        endcase
        if (rehunt) frame_phase = (b == cfg_mirror.sync_first) ? PH_SYNC2 : PH_HUNT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int seen, input int exp);
        $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, seen, exp);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (evt_if.valid && evt_if.ready) begin
                if (evt_expect_q.size() == 0) begin
                    report_mismatch("result with nothing pending, event_res",
                                    int'(evt_if.event_res), -1);
                end else begin
                    want = evt_expect_q.pop_front();
                    if (evt_if.event_res !== want.ev)
                        report_mismatch("event_res", int'(evt_if.event_res), int'(want.ev));
                    if (evt_if.payload_byte !== want.pb)
                        report_mismatch("payload_byte", int'(evt_if.payload_byte),
                                        int'(want.pb));
                    if (evt_if.byte_index !== want.idx)
                        report_mismatch("byte_index", int'(evt_if.byte_index),
                                        int'(want.idx));
                end
            end
            if (rx_if.valid && rx_if.ready) begin
                pin = pin_q.pop_front();
                got = deframe_step(rx_if.rx_byte);
                evt_expect_q.push_back(pin.pinned ? pin.want : got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 16);
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic put_byte(input logic [BYTE_W-1:0] b, input bit pinned, input t_evt_rec w);
        pin_q.push_back('{pinned, w});
        if (!quiet && $urandom_range(0, 7) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        put_byte(b, 1'b0, NO_EVT);
    endtask

    task automatic drain();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (evt_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_cfg(input t_cfg c);
        t_cfg_idx          regs [CFG_NUM];
        logic [BYTE_W-1:0] vals [CFG_NUM];
        regs = '{CFG_SYNC_FIRST, CFG_SYNC_SECOND, CFG_CLASS_VALUE, CFG_MESSAGE_VALUE,
                 CFG_PAYLOAD_LENGTH};
        vals = '{c.sync_first, c.sync_second, c.class_value, c.message_value,
                 c.payload_length};
        drain();
        for (int i = 0; i < CFG_NUM; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_mirror = c;
    endtask

    function automatic t_cfg random_cfg(input int max_len);
        t_cfg c;
        c.sync_first     = 8'($urandom);
        c.sync_second    = 8'($urandom);
        c.class_value    = 8'($urandom);
        c.message_value  = 8'($urandom);
        c.payload_length = 8'($urandom_range(1, max_len));
        return c;
    endfunction

    task automatic send_head(input int n_payload);
        send_byte(cfg_mirror.sync_first);
        send_byte(cfg_mirror.sync_second);
        send_byte(cfg_mirror.class_value);
        send_byte(cfg_mirror.message_value);
        repeat (n_payload) send_byte(8'($urandom));
    endtask

    task automatic finish_frame();
        drain();
        send_byte(fletch_a);
        send_byte(fletch_b);
    endtask

    task automatic send_frame(input t_flaw flaw, input int from);
        logic [BYTE_W-1:0] head [4];
        logic [BYTE_W-1:0] ck_a;
        logic [BYTE_W-1:0] ck_b;
        logic [BYTE_W-1:0] pay;
        int                cut;
        int                plen;
        head = '{cfg_mirror.sync_first, cfg_mirror.sync_second, cfg_mirror.class_value,
                 cfg_mirror.message_value};
        cut  = $urandom_range(1, 3);
        plen = (cfg_mirror.payload_length == 0) ? 256 : int'(cfg_mirror.payload_length);
        for (int i = from; i < 4; i++) begin
            if (flaw == FRAME_CUT && i == cut) begin
                send_byte($urandom_range(0, 1) ? cfg_mirror.sync_first : 8'($urandom));
                return;
            end
            send_byte(head[i]);
        end
        ck_a = head[2] + head[3];
        ck_b = head[2] + ck_a;
        repeat (plen) begin
            pay = 8'($urandom);
            send_byte(pay);
            ck_a = ck_a + pay;
            ck_b = ck_b + ck_a;
        end
        if (flaw == FRAME_BAD_A) begin
            send_byte(ck_a ^ 8'($urandom_range(1, 255)));
            return;
        end
        send_byte(ck_a);
        send_byte(flaw == FRAME_BAD_B ? ck_b ^ 8'($urandom_range(1, 255)) : ck_b);
    endtask

    task automatic send_random_frame();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
            repeat ($urandom_range(1, 5))
                send_byte($urandom_range(0, 3) == 0 ? cfg_mirror.sync_first : 8'($urandom));
        end else begin
            send_frame(pick < 6 ? FRAME_CLEAN : pick == 6 ? FRAME_CUT :
                       pick == 7 ? FRAME_BAD_A : FRAME_BAD_B, 0);
        end
    endtask

    // Reset sync/class/id with a one-byte payload
    t_dir_row dir_rows [29] = '{
        '{8'h00, 1'b1, NO_EVT},
        '{8'hFF, 1'b1, NO_EVT},
        '{8'hB5, 1'b0, NO_EVT},
        '{8'h62, 1'b0, NO_EVT},
        '{8'h01, 1'b0, NO_EVT},
        '{8'h05, 1'b0, NO_EVT},
        '{8'hFF, 1'b1, '{EV_PAYLOAD, 8'hFF, 8'h00}},
        '{8'h05, 1'b0, NO_EVT},
        '{8'h0C, 1'b1, GOOD},
        '{8'hB5, 1'b0, NO_EVT},
        '{8'h62, 1'b0, NO_EVT},
        '{8'h01, 1'b0, NO_EVT},
        '{8'h05, 1'b0, NO_EVT},
        '{8'h00, 1'b1, '{EV_PAYLOAD, 8'h00, 8'h00}},
        '{8'hB5, 1'b1, BAD},
        '{8'h62, 1'b1, NO_EVT},
        '{8'h01, 1'b0, NO_EVT},
        '{8'h05, 1'b0, NO_EVT},
        '{8'h00, 1'b1, NO_EVT},
        '{8'hB5, 1'b0, NO_EVT},
        '{8'hB5, 1'b0, NO_EVT},
        '{8'h62, 1'b0, NO_EVT},
        '{8'hB5, 1'b0, NO_EVT},
        '{8'h62, 1'b0, NO_EVT},
        '{8'h01, 1'b0, NO_EVT},
        '{8'h05, 1'b0, NO_EVT},
        '{8'h00, 1'b1, '{EV_PAYLOAD, 8'h00, 8'h00}},
        '{8'h06, 1'b0, NO_EVT},
        '{8'h00, 1'b1, BAD}
    };

    initial begin : stimulus
        t_cfg c;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_SYNC_FIRST;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        c = '{RST_SYNC_FIRST, RST_SYNC_SECOND, RST_CLASS_VALUE, RST_MESSAGE_VALUE, 8'd1};
        load_cfg(c);
        foreach (dir_rows[i]) put_byte(dir_rows[i].data, dir_rows[i].pinned, dir_rows[i].want);

        load_cfg('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'd1});
        repeat (5) send_random_frame();

        // shrink length mid-frame, staying above the count
        c = '{RST_SYNC_FIRST, RST_SYNC_SECOND, RST_CLASS_VALUE, RST_MESSAGE_VALUE, 8'd255};
        load_cfg(c);
        send_head(4);
        c.payload_length = 8'd6;
        load_cfg(c);
        repeat (2) send_byte(8'($urandom));
        finish_frame();

        // shrink below count to zero length: counter wraps through 256
        c.payload_length = 8'd20;
        load_cfg(c);
        send_head(10);
        c.payload_length = 8'd0;
        load_cfg(c);
        repeat (246) send_byte(8'($urandom));
        finish_frame();

        // swap the remaining header values after the first sync byte
        load_cfg(random_cfg(4));
        send_byte(cfg_mirror.sync_first);
        c = random_cfg(4);
        c.sync_first = cfg_mirror.sync_first;
        load_cfg(c);
        send_frame(FRAME_CLEAN, 1);

        repeat (3) begin
            quiet = ($urandom_range(0, 3) == 0);
            load_cfg(random_cfg(6));
            repeat (3) send_random_frame();
        end

        quiet = 1'b1;
        load_cfg(random_cfg(6));
        repeat (3) send_random_frame();

        drain();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
